@@ hdl/pss_pkg.sv @@
// ----------------------------------------------------------------------------
// pss_pkg
// shared types and constants of the pattern strip stream block
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_has_byte;
        logic              out_last;
    } t_out_item;

    // control of one group of results made by a single input transaction
    typedef struct packed {
        logic bare;   // lone end marker, no byte
        logic last;   // group closes the string
    } t_grp_ctl;

endpackage

@@ hdl/pss_intf.sv @@
// ----------------------------------------------------------------------------
// pss channel interfaces
// valid/ready channels for input bytes, output results and register writes
// ----------------------------------------------------------------------------
interface pss_in_if;
    logic              valid;
    logic              ready;
    pss_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pss_out_if;
    logic               valid;
    logic               ready;
    pss_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pss_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pss_pkg::CFG_IDX_W-1:0]      index;
    logic [pss_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/pattern_strip_stream.sv @@
// ----------------------------------------------------------------------------
// pattern_strip_stream
// removes every non-overlapping occurrence of a configured byte pattern
// ----------------------------------------------------------------------------
//
// channel   modport  payload                                  transaction
// i_in      sink     in_byte, in_last                         one string byte
// o_out     source   out_byte, out_has_byte, out_last         one kept byte or end marker
// i_cfg     sink     index, data                              one register write
//
// one input transaction per cycle while each byte yields at most one result and
// o_out does not stall; a byte that yields n results holds i_in until the
// single output register drains its group, one entry per cycle while o_out takes it
// i_rst_n is synchronous: window empties, pattern length 1, pattern bytes 0
// o_out stalls back up through the group buffer into i_in.ready; i_cfg never stalls
// ----------------------------------------------------------------------------
module pattern_strip_stream #(
    parameter int PAT_MAX = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pss_in_if.sink      i_in,
    pss_out_if.source   o_out,
    pss_cfg_if.sink     i_cfg
);

    localparam int CW = $clog2(PAT_MAX + 1);

    // configuration registers
    logic [pss_pkg::LEN_W-1:0]      r_len;
    logic [pss_pkg::CFG_DATA_W-1:0] r_pat;

    logic                           in_accept;
    logic                           in_ready;
    pss_pkg::t_grp_ctl              grp_ctl;
    logic [CW-1:0]                  grp_cnt;
    logic [pss_pkg::BYTE_W-1:0]     grp_bytes [PAT_MAX];

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign in_accept   = i_in.valid && in_ready;

    // register writes; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= pss_pkg::LEN_W'(1);
            r_pat <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pss_pkg::REG_PATTERN_LENGTH: r_len <= i_cfg.data[pss_pkg::LEN_W-1:0];
                pss_pkg::REG_PATTERN_BYTES:  r_pat <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // window update and compare, one input transaction per cycle unless the drain holds i_in
    pss_window #(
        .PAT_MAX (PAT_MAX)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_byte      (i_in.data.in_byte),
        .i_last      (i_in.data.in_last),
        .i_len_raw   (r_len),
        .i_pat       (r_pat),
        .o_grp_ctl   (grp_ctl),
        .o_grp_cnt   (grp_cnt),
        .o_grp_bytes (grp_bytes)
    );

    // result group buffer and output register
    pss_drain #(
        .PAT_MAX (PAT_MAX)
    ) u_drain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_accept),
        .i_grp_ctl   (grp_ctl),
        .i_grp_cnt   (grp_cnt),
        .i_grp_bytes (grp_bytes),
        .o_in_ready  (in_ready),
        .o_out       (o_out)
    );

endmodule

@@ hdl/pss_window.sv @@
// ----------------------------------------------------------------------------
// pss_window
// pending byte window, pattern compare and per-transaction result group
// ----------------------------------------------------------------------------
module pss_window #(
    parameter int PAT_MAX = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [pss_pkg::BYTE_W-1:0]         i_byte,
    input  logic                               i_last,
    input  logic [pss_pkg::LEN_W-1:0]          i_len_raw,
    input  logic [pss_pkg::CFG_DATA_W-1:0]     i_pat,
    output pss_pkg::t_grp_ctl                  o_grp_ctl,
    output logic [$clog2(PAT_MAX+1)-1:0]       o_grp_cnt,
    output logic [pss_pkg::BYTE_W-1:0]         o_grp_bytes [PAT_MAX]
);

    localparam int CW = $clog2(PAT_MAX + 1);
    localparam int IW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;

    logic [pss_pkg::BYTE_W-1:0] r_win [PAT_MAX];
    logic [pss_pkg::BYTE_W-1:0] n_win [PAT_MAX];
    logic [CW-1:0]              r_fill;
    logic [CW-1:0]              n_fill;

    logic [pss_pkg::BYTE_W-1:0] ext [PAT_MAX];
    logic [CW-1:0]              len;
    logic [CW-1:0]              cnt_m;
    logic [CW-1:0]              skip;
    logic [CW-1:0]              emit;
    logic                       full;
    logic                       hit;

    // effective pattern length, clamped to 1..PAT_MAX
    always_comb begin
        if (i_len_raw == '0) begin
            len = CW'(1);
        end else if (i_len_raw > pss_pkg::LEN_W'(PAT_MAX)) begin
            len = CW'(PAT_MAX);
        end else begin
            len = CW'(i_len_raw);
        end
    end

    // window with the incoming byte appended
    always_comb begin
        for (int i = 0; i < PAT_MAX; i++) begin
            ext[i] = (CW'(i) < r_fill) ? r_win[i] : i_byte;
        end
        cnt_m = r_fill + CW'(1);
        full  = (cnt_m >= len);
        skip  = (cnt_m > len) ? (cnt_m - len) : '0;
    end

    // compare the newest len bytes with the pattern
    always_comb begin
        logic [CW:0] sidx;
        hit  = full;
        sidx = '0;
        for (int i = 0; i < PAT_MAX; i++) begin
            sidx = {1'b0, skip} + (CW+1)'(i);
            if (CW'(i) < len) begin
                if (ext[sidx[IW-1:0]] != i_pat[8*i +: 8]) begin
                    hit = 1'b0;
                end
            end
        end
    end

    // bytes to emit from the front and what stays behind
    always_comb begin
        logic [CW:0] sj;
        sj = '0;
        priority if (i_last) begin
            emit   = hit ? skip : cnt_m;
            n_fill = '0;
        end else if (hit) begin
            emit   = skip;
            n_fill = '0;
        end else if (full) begin
            emit   = skip + CW'(1);
            n_fill = len - CW'(1);
        end else begin
            emit   = '0;
            n_fill = cnt_m;
        end
        for (int j = 0; j < PAT_MAX; j++) begin
            sj = {1'b0, emit} + (CW+1)'(j);
            if (sj < (CW+1)'(PAT_MAX)) begin
                n_win[j] = ext[sj[IW-1:0]];
            end else begin
                n_win[j] = r_win[j];
            end
        end
    end

    always_comb begin
        o_grp_ctl.bare = i_last && (emit == '0);
        o_grp_ctl.last = i_last;
        o_grp_cnt      = o_grp_ctl.bare ? CW'(1) : emit;
        o_grp_bytes    = ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

@@ hdl/pss_drain.sv @@
// ----------------------------------------------------------------------------
// pss_drain
// result group buffer, drained one result per cycle into the output register while o_out takes them
// ----------------------------------------------------------------------------
module pss_drain #(
    parameter int PAT_MAX = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  pss_pkg::t_grp_ctl                  i_grp_ctl,
    input  logic [$clog2(PAT_MAX+1)-1:0]       i_grp_cnt,
    input  logic [pss_pkg::BYTE_W-1:0]         i_grp_bytes [PAT_MAX],
    output logic                               o_in_ready,
    pss_out_if.source                          o_out
);

    localparam int CW = $clog2(PAT_MAX + 1);
    localparam int IW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;

    logic [pss_pkg::BYTE_W-1:0] r_gbytes [PAT_MAX];
    pss_pkg::t_grp_ctl          r_gctl;
    logic [CW-1:0]              r_grem;
    logic [IW-1:0]              r_gptr;
    logic                       r_oval;
    pss_pkg::t_out_item         r_odata;
    logic                       load_out;

    always_comb begin
        load_out   = (r_grem != '0) && (!r_oval || o_out.ready);
        o_in_ready = (r_grem == '0) || ((r_grem == CW'(1)) && load_out);
        o_out.valid = r_oval;
        o_out.data  = r_odata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grem <= '0;
            r_gptr <= '0;
            r_oval <= 1'b0;
        end else begin
            if (load_out) begin
                r_oval <= 1'b1;
            end else if (o_out.ready) begin
                r_oval <= 1'b0;
            end
            if (i_load) begin
                r_grem <= i_grp_cnt;
                r_gptr <= '0;
            end else if (load_out) begin
                r_grem <= r_grem - CW'(1);
                r_gptr <= r_gptr + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_gbytes <= i_grp_bytes;
            r_gctl   <= i_grp_ctl;
        end
        if (load_out) begin
            r_odata.out_byte     <= r_gctl.bare ? '0 : r_gbytes[r_gptr];
            r_odata.out_has_byte <= !r_gctl.bare;
            r_odata.out_last     <= r_gctl.last && (r_grem == CW'(1));
        end
    end

endmodule

@@ verif/tb_pattern_strip_stream.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pattern_strip_stream
// self-checking bench for the pattern strip block: a directed run through
// the corner cases of the pattern length and the end of string, then random
// strings built around the configured pattern under three idle mixes, with
// every kept byte and end marker compared against a predictor of the window
// ----------------------------------------------------------------------------
module tb_pattern_strip_stream;

    localparam int PAT_MAX           = 8;
    localparam int CLK_HALF          = 5;
    localparam int RESET_CYCLES      = 10;
    // quiet cycles after the last expected result before a register write
    localparam int SETTLE_CYCLES     = PAT_MAX + 4;
    localparam int HOLD_CYCLES       = 300;
    localparam int CYCLE_LIMIT       = 200000;
    localparam int END_LIMIT         = 5000;
    localparam int MAX_REPORTS       = 10;
    localparam int ITEMS_PER_SETTING = 30;
    localparam int NUM_SETTINGS      = 4;

    typedef logic [pss_pkg::BYTE_W-1:0] t_byte_q [$];

    // predictor of the strip window plus the queue of kept bytes still owed
    class t_strip_scoreboard;
        logic [pss_pkg::BYTE_W-1:0]     win [PAT_MAX];
        int unsigned                    fill;
        logic [pss_pkg::LEN_W-1:0]      pat_len;
        logic [pss_pkg::CFG_DATA_W-1:0] pat_bytes;
        pss_pkg::t_out_item             kept_q [$];
        int unsigned                    mismatches;
        int unsigned                    checked;
        int unsigned                    bytes_in;
        int unsigned                    reg_writes;

        function new();
            foreach (win[i]) win[i] = '0;
            fill       = 0;
            pat_len    = pss_pkg::LEN_W'(1);
            pat_bytes  = '0;
            mismatches = 0;
            checked    = 0;
            bytes_in   = 0;
            reg_writes = 0;
        endfunction

        function void set_reg(input logic [pss_pkg::CFG_IDX_W-1:0] idx,
                              input logic [pss_pkg::CFG_DATA_W-1:0] val);
            if (idx == pss_pkg::REG_PATTERN_LENGTH) pat_len = val[pss_pkg::LEN_W-1:0];
            else if (idx == pss_pkg::REG_PATTERN_BYTES) pat_bytes = val;
            reg_writes++;
        endfunction

        // zero acts as one, anything past the window acts as the window size
        function int unsigned eff_len();
            int unsigned len;
            len = 32'(pat_len);
            if (len < 1) len = 1;
            if (len > PAT_MAX) len = PAT_MAX;
            return len;
        endfunction

        function logic [pss_pkg::BYTE_W-1:0] pat_byte(input int unsigned k);
            return pat_bytes[pss_pkg::BYTE_W*k +: pss_pkg::BYTE_W];
        endfunction

        function void keep_oldest();
            pss_pkg::t_out_item r;
            int unsigned        i;
            r.out_byte     = win[0];
            r.out_has_byte = 1'b1;
            r.out_last     = 1'b0;
            for (i = 1; i < fill; i++) win[i-1] = win[i];
            fill--;
            kept_q.push_back(r);
        endfunction

        function bit window_hit(input int unsigned len);
            int unsigned i;
            for (i = 0; i < len; i++)
                if (win[i] !== pat_byte(i)) return 1'b0;
            return 1'b1;
        endfunction

        function void note_byte(input pss_pkg::t_in_item item);
            int unsigned        len;
            int unsigned        n0;
            pss_pkg::t_out_item r;
            len = eff_len();
            n0  = kept_q.size();
            bytes_in++;
            if (fill >= PAT_MAX) keep_oldest();
            win[fill] = item.in_byte;
            fill++;
            // a shrunk length pushes the surplus out before the compare
            while (fill > len) keep_oldest();
            if (fill == len) begin
                if (window_hit(len)) fill = 0;
                else if (!item.in_last) keep_oldest();
            end
            if (item.in_last) begin
                while (fill > 0) keep_oldest();
                if (kept_q.size() == n0) begin
                    r          = '0;
                    r.out_last = 1'b1;
                    kept_q.push_back(r);
                end else begin
                    kept_q[kept_q.size()-1].out_last = 1'b1;
                end
            end
        endfunction

        function void check_result(input pss_pkg::t_out_item got);
            pss_pkg::t_out_item want;
            checked++;
            if (kept_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d unexpected: byte=%02h has=%0b last=%0b",
                             checked, got.out_byte, got.out_has_byte, got.out_last);
                return;
            end
            want = kept_q.pop_front();
            if (got.out_byte !== want.out_byte || got.out_has_byte !== want.out_has_byte ||
                got.out_last !== want.out_last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"result %0d: expected byte=%02h has=%0b last=%0b,",
                              " got byte=%02h has=%0b last=%0b"},
                             checked, want.out_byte, want.out_has_byte, want.out_last,
                             got.out_byte, got.out_has_byte, got.out_last);
            end
        endfunction

        function int unsigned pending();
            return kept_q.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    int unsigned       src_idle_pct;
    int unsigned       snk_idle_pct;
    bit                hold_req;
    int unsigned       cycles = 0;
    int unsigned       str_left;   // bytes still to go in the current random string
    t_strip_scoreboard sb;

    pss_in_if  in_if ();
    pss_out_if out_if ();
    pss_cfg_if cfg_if ();

    pattern_strip_stream #(
        .PAT_MAX (PAT_MAX)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run guard, far above the slowest legal run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_pattern_strip_stream: FAIL");
            $finish;
        end
    end

    // both channels are observed in one process so a byte is always noted
    // before any result of the same edge is checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
                sb.note_byte(in_if.data);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
                sb.check_result(out_if.data);
        end
    end

    // result side: random back pressure, or one long counted hold on request
    initial begin : result_sink
        int unsigned held;
        bit          hold_done;
        hold_done    = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                out_if.ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // one string byte, with random idle cycles ahead of it
    task automatic send_byte(input logic [pss_pkg::BYTE_W-1:0] b, input logic is_last);
        pss_pkg::t_in_item item;
        item.in_byte = b;
        item.in_last = is_last;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= item;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
    endtask

    task automatic send_string(input t_byte_q s, input logic close);
        foreach (s[i]) send_byte(s[i], close && (i == s.size() - 1));
    endtask

    // drop valid and wait until every owed result is in and the block is quiet
    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [pss_pkg::CFG_IDX_W-1:0] idx,
                               input logic [pss_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // one register setting per slot: short patterns over a two letter
    // alphabet, full window, the length extremes, and anything at all
    task automatic pick_setting(input int unsigned k);
        logic [pss_pkg::CFG_DATA_W-1:0] len_word;
        logic [pss_pkg::CFG_DATA_W-1:0] pat;
        int unsigned                    i;
        len_word = {$urandom, $urandom};
        pat      = {$urandom, $urandom};
        case (k % 4)
            0: begin
                len_word[pss_pkg::LEN_W-1:0] = pss_pkg::LEN_W'($urandom_range(3, 1));
                for (i = 0; i < PAT_MAX; i++)
                    pat[pss_pkg::BYTE_W*i +: pss_pkg::BYTE_W] =
                        $urandom_range(1) ? 8'h61 : 8'h62;
            end
            1: len_word[pss_pkg::LEN_W-1:0] = pss_pkg::LEN_W'(PAT_MAX);
            2: begin
                // length zero with an all-zero pattern, or the top length with all ones
                len_word[pss_pkg::LEN_W-1:0] = (k % 8 == 2) ? '0 : '1;
                pat                          = (k % 8 == 2) ? '0 : '1;
            end
            default: len_word[pss_pkg::LEN_W-1:0] = pss_pkg::LEN_W'($urandom_range(15, 0));
        endcase
        program_reg(pss_pkg::REG_PATTERN_LENGTH, len_word);
        program_reg(pss_pkg::REG_PATTERN_BYTES, pat);
    endtask

    // random strings built from whole patterns, broken prefixes, pattern
    // bytes out of place and plain noise; strings run across settings
    task automatic send_random(input int unsigned count);
        t_byte_q     chunk;
        int unsigned sent;
        int unsigned len;
        int unsigned cut;
        int unsigned i;
        int unsigned r;
        sent = 0;
        while (sent < count) begin
            len   = sb.eff_len();
            chunk = {};
            r     = $urandom_range(99);
            if (r < 35) begin
                for (i = 0; i < len; i++) chunk.push_back(sb.pat_byte(i));
            end else if (r < 50) begin
                cut = $urandom_range(len - 1, 0);
                for (i = 0; i < cut; i++) chunk.push_back(sb.pat_byte(i));
                chunk.push_back(pss_pkg::BYTE_W'($urandom_range(255, 0)));
            end else if (r < 80) begin
                chunk.push_back(sb.pat_byte($urandom_range(len - 1, 0)));
            end else begin
                chunk.push_back(pss_pkg::BYTE_W'($urandom_range(255, 0)));
            end
            foreach (chunk[j]) begin
                if (sent >= count) break;
                send_byte(chunk[j], str_left == 1);
                if (str_left == 1)
                    str_left = ($urandom_range(99) < 85) ? $urandom_range(12, 1)
                                                         : $urandom_range(48, 13);
                else
                    str_left--;
                sent++;
            end
        end
    endtask

    initial begin : main_flow
        t_byte_q     s;
        int unsigned phase;
        int unsigned setting;
        int unsigned n;
        sb            = new();
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.data    = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        src_idle_pct  = 20;
        snk_idle_pct  = 20;
        hold_req      = 1'b0;
        str_left      = 5;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset pattern is one zero byte: zeros vanish, a lone zero leaves a bare marker
        s = {8'h00, 8'hff, 8'h00};
        send_string(s, 1'b1);
        s = {8'h00};
        send_string(s, 1'b1);
        settle();

        // length zero behaves as one, upper register bits ignored
        program_reg(pss_pkg::REG_PATTERN_LENGTH, 64'hffff_ffff_ffff_fff0);
        program_reg(pss_pkg::REG_PATTERN_BYTES, 64'h5a5a_5a5a_5a5a_5a41);
        s = {8'h41, 8'h42, 8'h41};
        send_string(s, 1'b1);
        settle();

        // length past the window clamps to eight, whole string matches
        program_reg(pss_pkg::REG_PATTERN_LENGTH, 64'h0f);
        program_reg(pss_pkg::REG_PATTERN_BYTES, '1);
        s = {};
        repeat (PAT_MAX) s.push_back(8'hff);
        send_string(s, 1'b1);
        settle();

        // greedy left to right: overlapping second occurrence survives
        program_reg(pss_pkg::REG_PATTERN_LENGTH, 64'h3);
        program_reg(pss_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0061_6261);
        s = {8'h61, 8'h62, 8'h61, 8'h62, 8'h61};
        send_string(s, 1'b1);
        settle();

        // length shrunk while the window holds more than the new length
        program_reg(pss_pkg::REG_PATTERN_LENGTH, 64'h4);
        program_reg(pss_pkg::REG_PATTERN_BYTES, 64'h0000_0000_7a79_7877);
        s = {8'h77, 8'h78};
        send_string(s, 1'b0);
        settle();
        program_reg(pss_pkg::REG_PATTERN_LENGTH, 64'h1);
        program_reg(pss_pkg::REG_PATTERN_BYTES, 64'h78);
        s = {8'h71};
        send_string(s, 1'b1);
        settle();

        // pattern swapped mid-string, then a pattern holding a zero byte
        program_reg(pss_pkg::REG_PATTERN_LENGTH, 64'h2);
        program_reg(pss_pkg::REG_PATTERN_BYTES, 64'h6261);
        s = {8'h61};
        send_string(s, 1'b0);
        settle();
        program_reg(pss_pkg::REG_PATTERN_BYTES, 64'h0063);
        s = {8'h62};
        send_string(s, 1'b1);
        s = {8'h63, 8'h00};
        send_string(s, 1'b1);

        // random part: receiver-heavy idling, sender-heavy idling, then none
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 32; snk_idle_pct = 45; end
                1: begin src_idle_pct = 45; snk_idle_pct = 32; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            for (setting = 0; setting < NUM_SETTINGS; setting++) begin
                settle();
                pick_setting(phase * NUM_SETTINGS + setting);
                // long output stall while bytes keep coming, fills the block
                if (phase == 2 && setting == 1) hold_req = 1'b1;
                send_random(ITEMS_PER_SETTING);
            end
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        for (n = 0; n < END_LIMIT && sb.pending() != 0; n++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d string bytes, %0d results and %0d register writes",
                 sb.bytes_in, sb.checked, sb.reg_writes);
        $display("over three idle mixes, a long output stall, %0d mismatches, %0d results missing",
                 sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_pattern_strip_stream: PASS");
        end else begin
            $display("tb_pattern_strip_stream: FAIL");
        end
        $finish;
    end

endmodule
